// ----- hw/rtl/jst_pkg.sv -----
// shared constants and types for the job status table
package jst_pkg;

  localparam int MAX_ENTRIES  = 64;
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W         = 32;
  localparam int PCT_W        = 7;
  localparam int USED_W       = 7;

  localparam logic [PCT_W-1:0] FULL_PERCENT = PCT_W'(100);

  // command codes
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_PROGRESS = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;
  localparam logic [1:0] CMD_REMOVE   = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PCT_W-1:0] pct;
    logic             fin;
    logic             fail;
  } entry_t;

  // controls broadcast to every cell during the execute cycle
  typedef struct packed {
    logic             exec;
    logic [1:0]       cmd;
    logic [ID_W-1:0]  job_id;
    logic [PCT_W-1:0] pct;
    logic             fail;
    logic             room;
    logic             all_shift;
    logic             drop_en;
  } cmd_bus_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
    return (v > FULL_PERCENT) ? FULL_PERCENT : v;
  endfunction

endpackage

// ----- hw/rtl/jst_cell.sv -----
// one table entry with its match and shift logic
module jst_cell (
  input  logic             clk,
  input  jst_pkg::cmd_bus_t bus,
  input  logic             valid,
  input  jst_pkg::entry_t  left_ent,
  input  jst_pkg::entry_t  right_ent,
  input  logic             hit_in,
  input  logic             older_fin_in,
  output jst_pkg::entry_t  ent,
  output logic             hit_out,
  output logic             older_fin_out,
  output logic             first_fin,
  output logic             victim,
  output logic             fin_nxt
);
  import jst_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   match;
  logic   first;
  logic   older_incl;

  assign match         = valid && (ent_r.id == bus.job_id);
  assign first         = match && !hit_in;
  assign hit_out       = hit_in || match;
  assign older_incl    = older_fin_in || (valid && ent_r.fin);
  assign older_fin_out = older_incl;
  assign first_fin     = first && ent_r.fin;
  assign victim        = valid && ent_r.fin && !older_fin_in;
  assign ent           = ent_r;
  assign fin_nxt       = ent_nxt.fin;

  always_comb begin
    ent_nxt = ent_r;
    if (bus.exec) begin
      unique case (bus.cmd)
        CMD_ADD: begin
          if (bus.room && (bus.all_shift || older_incl)) ent_nxt = left_ent;
        end
        CMD_PROGRESS: begin
          if (first) ent_nxt.pct = bus.pct;
        end
        CMD_FINISH: begin
          if (first) begin
            ent_nxt.fin  = 1'b1;
            ent_nxt.fail = bus.fail;
            ent_nxt.pct  = FULL_PERCENT;
          end
        end
        CMD_REMOVE: begin
          if (bus.drop_en && hit_out) ent_nxt = right_ent;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- hw/rtl/job_status_table.sv -----
// top level of the job status table: command latch, cell chain and result register
// A command is taken when start is high and busy is low; busy then stays high for
// one cycle while the cell chain executes, and the result appears on the out_
// ports for exactly one cycle with out_strobe high. A new command cannot be
// taken until the execute cycle of the last one is over; in that execute cycle
// all cells compare ids, locate the oldest finished entry and shift in
// parallel. The result cannot be stalled: it must be taken in the cycle that
// out_strobe is high. Entry 0 is the newest; entries at or above the fill count
// are ignored, so no clearing is needed after reset.
module job_status_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_cmd,
  input  logic [jst_pkg::ID_W-1:0] in_job_id,
  input  logic [jst_pkg::PCT_W-1:0] in_progress_value,
  input  logic                     in_fail_flag,
  output logic                     out_strobe,
  output logic [jst_pkg::ID_W-1:0] out_issued_id,
  output logic                     out_id_found,
  output logic                     out_op_done,
  output logic                     out_table_full,
  output logic                     out_evicted_valid,
  output logic [jst_pkg::ID_W-1:0] out_evicted_job,
  output logic                     out_finish_event,
  output logic                     out_finish_failed,
  output logic                     out_any_active,
  output logic [jst_pkg::USED_W-1:0] out_entries_used
);
  import jst_pkg::*;

  // control state
  logic             busy_r;
  logic             strobe_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ID_W-1:0]  id_cnt_r;

  // latched command transaction
  logic [1:0]       cmd_r;
  logic [ID_W-1:0]  job_id_r;
  logic [PCT_W-1:0] pct_r;
  logic             fail_r;

  // cell chain wiring
  cmd_bus_t                bus;
  entry_t                  ents   [MAX_ENTRIES];
  entry_t                  new_ent;
  logic [MAX_ENTRIES:0]    hit;
  logic [MAX_ENTRIES:0]    ofin;
  logic [MAX_ENTRIES-1:0]  valid, valid_nxt, first_fin, victim, fin_nxt;

  // execute-cycle decisions
  logic            is_add, is_prog, is_fin, is_rem;
  logic            tab_full, any_fin, room, found, drop_en, add_ok;
  logic [ID_W-1:0] ev_id;

  assign is_add  = (cmd_r == CMD_ADD);
  assign is_prog = (cmd_r == CMD_PROGRESS);
  assign is_fin  = (cmd_r == CMD_FINISH);
  assign is_rem  = (cmd_r == CMD_REMOVE);

  assign tab_full = (count_r == CNT_W'(MAX_ENTRIES));
  assign any_fin  = ofin[0];
  assign room     = !tab_full || any_fin;
  assign found    = hit[MAX_ENTRIES];
  assign drop_en  = |first_fin;
  assign add_ok   = is_add && room;

  assign bus.exec      = busy_r;
  assign bus.cmd       = cmd_r;
  assign bus.job_id    = job_id_r;
  assign bus.pct       = pct_r;
  assign bus.fail      = fail_r;
  assign bus.room      = room;
  assign bus.all_shift = !tab_full;
  assign bus.drop_en   = drop_en;

  // fresh entry enters at the head on an add
  assign new_ent.id   = id_cnt_r;
  assign new_ent.pct  = '0;
  assign new_ent.fin  = 1'b0;
  assign new_ent.fail = 1'b0;

  // newest-first match chain and oldest-first finished chain
  assign hit[0]            = 1'b0;
  assign ofin[MAX_ENTRIES] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      entry_t lft, rgt;
      assign valid[gi]     = (CNT_W'(gi) < count_r);
      assign valid_nxt[gi] = (CNT_W'(gi) < count_nxt);
      if (gi == 0) begin : g_head
        assign lft = new_ent;
      end else begin : g_body_l
        assign lft = ents[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign rgt = ents[gi];
      end else begin : g_body_r
        assign rgt = ents[gi+1];
      end
      jst_cell u_cell (
        .clk           (clk),
        .bus           (bus),
        .valid         (valid[gi]),
        .left_ent      (lft),
        .right_ent     (rgt),
        .hit_in        (hit[gi]),
        .older_fin_in  (ofin[gi+1]),
        .ent           (ents[gi]),
        .hit_out       (hit[gi+1]),
        .older_fin_out (ofin[gi]),
        .first_fin     (first_fin[gi]),
        .victim        (victim[gi]),
        .fin_nxt       (fin_nxt[gi])
      );
    end
  endgenerate

  // id of the oldest finished entry, one-hot select
  always_comb begin
    ev_id = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (victim[i]) ev_id = ev_id | ents[i].id;
    end
  end

  // fill count after this command
  always_comb begin
    count_nxt = count_r;
    if (busy_r) begin
      if (add_ok && !tab_full) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (is_rem && drop_en) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      count_r  <= '0;
      id_cnt_r <= '0;
    end else begin
      strobe_r <= busy_r;
      count_r  <= count_nxt;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
      if (busy_r && add_ok) id_cnt_r <= id_cnt_r + ID_W'(1);
    end
  end

  // command latch and result register
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cmd_r    <= in_cmd;
      job_id_r <= in_job_id;
      pct_r    <= clamp_pct(in_progress_value);
      fail_r   <= in_fail_flag;
    end
    if (busy_r) begin
      out_issued_id     <= add_ok ? id_cnt_r : '0;
      out_id_found      <= !is_add && found;
      out_op_done       <= add_ok || ((is_prog || is_fin) && found) || (is_rem && drop_en);
      out_table_full    <= is_add && !room;
      out_evicted_valid <= add_ok && tab_full;
      out_evicted_job   <= (add_ok && tab_full) ? ev_id : '0;
      out_finish_event  <= is_fin && found;
      out_finish_failed <= is_fin && found && fail_r;
      out_any_active    <= |(valid_nxt & ~fin_nxt);
      out_entries_used  <= USED_W'(count_nxt);
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

  // every execute cycle is followed by a result strobe in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |=> strobe_r)
    else $error("execute cycle did not produce a result");

  // fill count never exceeds the table size
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(MAX_ENTRIES))
    else $error("fill count beyond table size");

  // a refused add reports neither a completed operation nor an eviction
  assert property (@(posedge clk) disable iff (!rst_n)
      (strobe_r && out_table_full) |-> (!out_op_done && !out_evicted_valid))
    else $error("refused add reported a change");

  // an eviction only happens when the table was full and stays full
  assert property (@(posedge clk) disable iff (!rst_n)
      (busy_r && add_ok && tab_full) |=> (count_r == CNT_W'(MAX_ENTRIES)))
    else $error("eviction changed the fill count");

endmodule
